/* src/osp_fr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// osp_fr_pkg
// Shared types and codes for the binary frame receiver.
// ----------------------------------------------------------------------------
package osp_fr_pkg;

  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned LenWidth  = 16;
  localparam int unsigned SumWidth  = 15;
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic [CfgWidth-1:0] PATIENCE_RESET = 16'd2048;
  localparam logic [CfgWidth-1:0] MAX_LEN_RESET  = 16'd1020;

  localparam logic [7:0] START_A = 8'hA0;
  localparam logic [7:0] START_B = 8'hA2;

  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_TIMEOUT = 2'd1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SUM   = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_LEN_RANGE = 3'd3;
  localparam logic [2:0] ST_LEN_SHORT = 3'd4;
  localparam logic [2:0] ST_LEN_ERR   = 3'd5;
  localparam logic [2:0] ST_NO_SYNC   = 3'd6;

  typedef struct packed {
    logic [CfgWidth-1:0] patience_limit;
    logic [CfgWidth-1:0] max_length;
    logic                reload;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic                kind;
    logic [7:0]          payload_byte;
    logic [LenWidth-1:0] byte_index;
    logic [LenWidth-1:0] frame_length;
    logic [2:0]          status;
  } res_t;

endpackage

`default_nettype wire

/* src/osp_fr_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// osp_fr_regs
// APB-style register file: patience limit and maximum payload length.
// ----------------------------------------------------------------------------
module osp_fr_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [osp_fr_pkg::AddrWidth-1:0]    paddr,
  input  wire logic [osp_fr_pkg::DataWidth-1:0]    pwdata,
  output logic      [osp_fr_pkg::DataWidth-1:0]    prdata,
  output logic                                     pready,
  output osp_fr_pkg::cfg_t                         cfg
);

  localparam logic REG_PATIENCE = 1'b0;
  localparam logic REG_MAX_LEN  = 1'b1;

  logic [osp_fr_pkg::CfgWidth-1:0] patience_r, patience_nxt;
  logic [osp_fr_pkg::CfgWidth-1:0] max_len_r, max_len_nxt;
  logic                            wr_en;
  logic                            reload_r, reload_nxt;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    patience_nxt = patience_r;
    max_len_nxt  = max_len_r;
    reload_nxt   = 1'b0;
    if (wr_en) begin
      unique case (paddr[2])
        REG_PATIENCE: begin
          patience_nxt = pwdata[osp_fr_pkg::CfgWidth-1:0];
          reload_nxt   = 1'b1;
        end
        REG_MAX_LEN: max_len_nxt = pwdata[osp_fr_pkg::CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patience_r <= osp_fr_pkg::PATIENCE_RESET;
      max_len_r  <= osp_fr_pkg::MAX_LEN_RESET;
      reload_r   <= 1'b0;
    end else begin
      patience_r <= patience_nxt;
      max_len_r  <= max_len_nxt;
      reload_r   <= reload_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PATIENCE: prdata = {16'd0, patience_r};
      REG_MAX_LEN:  prdata = {16'd0, max_len_r};
      default:      prdata = '0;
    endcase
  end

  assign cfg.patience_limit = patience_r;
  assign cfg.max_length     = max_len_r;
  assign cfg.reload         = reload_r;

endmodule

`default_nettype wire

/* src/osp_fr_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// osp_fr_core
// Frame state machine: sync hunt, length, payload sum and checksum compare.
// ----------------------------------------------------------------------------
module osp_fr_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire logic [1:0]         action,
  input  wire logic [7:0]         rx_byte,
  input  wire osp_fr_pkg::cfg_t   cfg,
  output osp_fr_pkg::res_t        res
);

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHKHI = 3'd5,
    PH_CHKLO = 3'd6
  } phase_t;

  phase_t                             phase_r, phase_nxt;
  logic [osp_fr_pkg::CfgWidth-1:0]    patience_left_r, patience_left_nxt;
  logic [7:0]                         length_high_r, length_high_nxt;
  logic [osp_fr_pkg::LenWidth-1:0]    payload_length_r, payload_length_nxt;
  logic [osp_fr_pkg::LenWidth-1:0]    byte_count_r, byte_count_nxt;
  logic [osp_fr_pkg::SumWidth-1:0]    running_sum_r, running_sum_nxt;
  logic [7:0]                         check_high_r, check_high_nxt;

  logic                               got;
  logic                               spend;
  logic                               emit;
  logic                               hunt;
  logic [2:0]                         st;
  logic [osp_fr_pkg::LenWidth-1:0]    len;
  logic [osp_fr_pkg::LenWidth-1:0]    new_len;
  logic [osp_fr_pkg::LenWidth-1:0]    count_inc;

  assign got       = (action == osp_fr_pkg::ACT_BYTE);
  assign new_len   = {length_high_r, rx_byte};
  assign count_inc = byte_count_r + 16'd1;

  always_comb begin
    phase_nxt          = phase_r;
    patience_left_nxt  = patience_left_r;
    length_high_nxt    = length_high_r;
    payload_length_nxt = payload_length_r;
    byte_count_nxt     = byte_count_r;
    running_sum_nxt    = running_sum_r;
    check_high_nxt     = check_high_r;
    res                = '0;
    spend              = 1'b0;
    emit               = 1'b0;
    hunt               = 1'b0;
    st                 = osp_fr_pkg::ST_OK;
    len                = '0;

    unique case (phase_r)
      PH_HUNT1: begin
        if (!got) begin
          spend = 1'b1;
        end else if (rx_byte == osp_fr_pkg::START_A) begin
          phase_nxt = PH_HUNT2;
        end else if (rx_byte != osp_fr_pkg::START_B) begin
          spend = 1'b1;
        end
      end
      PH_HUNT2: begin
        if (!got) begin
          spend = 1'b1;
        end else if (rx_byte == osp_fr_pkg::START_B) begin
          phase_nxt = PH_LENHI;
        end else if (rx_byte != osp_fr_pkg::START_A) begin
          phase_nxt = PH_HUNT1;
          spend     = 1'b1;
        end
      end
      PH_LENHI: begin
        if (!got) begin
          emit = 1'b1;
          st   = (action == osp_fr_pkg::ACT_TIMEOUT) ? osp_fr_pkg::ST_LEN_SHORT
                                                     : osp_fr_pkg::ST_LEN_ERR;
        end else begin
          length_high_nxt = rx_byte;
          phase_nxt       = PH_LENLO;
        end
      end
      PH_LENLO: begin
        if (!got) begin
          emit = 1'b1;
          st   = (action == osp_fr_pkg::ACT_TIMEOUT) ? osp_fr_pkg::ST_LEN_SHORT
                                                     : osp_fr_pkg::ST_LEN_ERR;
        end else if (new_len == '0 || new_len > cfg.max_length) begin
          emit = 1'b1;
          st   = osp_fr_pkg::ST_LEN_RANGE;
          len  = new_len;
        end else begin
          payload_length_nxt = new_len;
          byte_count_nxt     = '0;
          running_sum_nxt    = '0;
          phase_nxt          = PH_DATA;
        end
      end
      PH_DATA: begin
        if (!got) begin
          emit = 1'b1;
          st   = osp_fr_pkg::ST_SHORT;
          len  = payload_length_r;
        end else begin
          res.valid        = 1'b1;
          res.kind         = osp_fr_pkg::KIND_PAYLOAD;
          res.payload_byte = rx_byte;
          res.byte_index   = byte_count_r;
          res.frame_length = payload_length_r;
          res.status       = osp_fr_pkg::ST_OK;
          running_sum_nxt  = running_sum_r + {7'd0, rx_byte};
          byte_count_nxt   = count_inc;
          if (count_inc >= payload_length_r) begin
            phase_nxt = PH_CHKHI;
          end
        end
      end
      PH_CHKHI: begin
        if (!got) begin
          emit = 1'b1;
          st   = osp_fr_pkg::ST_SHORT;
          len  = payload_length_r;
        end else begin
          check_high_nxt = rx_byte;
          phase_nxt      = PH_CHKLO;
        end
      end
      PH_CHKLO: begin
        emit = 1'b1;
        len  = payload_length_r;
        if (!got) begin
          st = osp_fr_pkg::ST_SHORT;
        end else if ({check_high_r, rx_byte} == {1'b0, running_sum_r}) begin
          st = osp_fr_pkg::ST_OK;
        end else begin
          st = osp_fr_pkg::ST_BAD_SUM;
        end
      end
      default: hunt = 1'b1;
    endcase

    if (spend) begin
      if (patience_left_r <= 16'd1) begin
        emit = 1'b1;
        st   = osp_fr_pkg::ST_NO_SYNC;
        len  = '0;
      end else begin
        patience_left_nxt = patience_left_r - 16'd1;
      end
    end

    if (emit) begin
      res.valid        = 1'b1;
      res.kind         = osp_fr_pkg::KIND_STATUS;
      res.payload_byte = '0;
      res.byte_index   = byte_count_r;
      res.frame_length = len;
      res.status       = st;
      hunt             = 1'b1;
    end

    if (hunt) begin
      phase_nxt          = PH_HUNT1;
      patience_left_nxt  = cfg.patience_limit;
      length_high_nxt    = '0;
      payload_length_nxt = '0;
      byte_count_nxt     = '0;
      running_sum_nxt    = '0;
      check_high_nxt     = '0;
    end

    // hold state unless a beat advances; a patience write still reloads the counter while hunting
    if (!step_en) begin
      phase_nxt          = phase_r;
      patience_left_nxt  = patience_left_r;
      length_high_nxt    = length_high_r;
      payload_length_nxt = payload_length_r;
      byte_count_nxt     = byte_count_r;
      running_sum_nxt    = running_sum_r;
      check_high_nxt     = check_high_r;
      if (cfg.reload && (phase_r == PH_HUNT1 || phase_r == PH_HUNT2)) begin
        patience_left_nxt = cfg.patience_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HUNT1;
      patience_left_r  <= osp_fr_pkg::PATIENCE_RESET;
      length_high_r    <= '0;
      payload_length_r <= '0;
      byte_count_r     <= '0;
      running_sum_r    <= '0;
      check_high_r     <= '0;
    end else begin
      phase_r          <= phase_nxt;
      patience_left_r  <= patience_left_nxt;
      length_high_r    <= length_high_nxt;
      payload_length_r <= payload_length_nxt;
      byte_count_r     <= byte_count_nxt;
      running_sum_r    <= running_sum_nxt;
      check_high_r     <= check_high_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/osp_frame_receiver_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// osp_frame_receiver_unit
// Streaming deframer: start-pair hunt, length check, payload pass-through
// and checksum compare, one link event per beat.
// ----------------------------------------------------------------------------
// Path: an accepted beat is held in the input register, then the frame state
//   machine writes its result into the result register.
// Throughput: one input beat per cycle while the result slot is free or the beat makes no result.
// Reset: synchronous, active low; clears both registers' valid flags, loads
//   patience limit 2048 and maximum length 1020, and starts the sync hunt.
module osp_frame_receiver_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_action,
  input  wire logic [7:0]                          in_rx_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_kind,
  output logic      [7:0]                          out_payload_byte,
  output logic      [osp_fr_pkg::LenWidth-1:0]     out_byte_index,
  output logic      [osp_fr_pkg::LenWidth-1:0]     out_frame_length,
  output logic      [2:0]                          out_status,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [osp_fr_pkg::AddrWidth-1:0]    paddr,
  input  wire logic [osp_fr_pkg::DataWidth-1:0]    pwdata,
  output logic      [osp_fr_pkg::DataWidth-1:0]    prdata,
  output logic                                     pready
);

  osp_fr_pkg::cfg_t cfg;
  osp_fr_pkg::res_t res;
  osp_fr_pkg::res_t out_r, out_nxt;

  logic       in_valid_r, in_valid_nxt;
  logic [1:0] action_r, action_nxt;
  logic [7:0] rx_byte_r, rx_byte_nxt;
  logic       advance;
  logic       in_take;

  osp_fr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  osp_fr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .action  (action_r),
    .rx_byte (rx_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // advance the held beat when the result slot is free or no result is made
  assign advance  = in_valid_r & (~out_r.valid | out_ready | ~res.valid);
  assign in_ready = ~in_valid_r | advance;
  assign in_take  = in_valid & in_ready;

  always_comb begin
    in_valid_nxt = in_take | (in_valid_r & ~advance);
    action_nxt   = in_take ? in_action  : action_r;
    rx_byte_nxt  = in_take ? in_rx_byte : rx_byte_r;
    out_nxt      = out_r;
    if (advance && res.valid) begin
      out_nxt = res;
    end else if (out_ready) begin
      out_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_r      <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_r      <= out_nxt;
    end
    action_r  <= action_nxt;
    rx_byte_r <= rx_byte_nxt;
  end

  assign out_valid        = out_r.valid;
  assign out_kind         = out_r.kind;
  assign out_payload_byte = out_r.payload_byte;
  assign out_byte_index   = out_r.byte_index;
  assign out_frame_length = out_r.frame_length;
  assign out_status       = out_r.status;

endmodule

`default_nettype wire

/* src/osp_fr_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// osp_fr_chk
// Port-level checks on the frame receiver's result channel.
// ----------------------------------------------------------------------------
module osp_fr_chk (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire logic                                out_kind,
  input  wire logic [7:0]                          out_payload_byte,
  input  wire logic [osp_fr_pkg::LenWidth-1:0]     out_byte_index,
  input  wire logic [osp_fr_pkg::LenWidth-1:0]     out_frame_length,
  input  wire logic [2:0]                          out_status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_payload_byte) && $stable(out_byte_index)
      && $stable(out_status))
    else $error("result beat changed while stalled");

  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == osp_fr_pkg::KIND_PAYLOAD
      |-> out_status == osp_fr_pkg::ST_OK && out_byte_index < out_frame_length)
    else $error("payload beat outside its frame");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == osp_fr_pkg::KIND_STATUS |-> out_status <= osp_fr_pkg::ST_NO_SYNC
      && out_payload_byte == 8'd0)
    else $error("bad frame status beat");

  a_early_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == osp_fr_pkg::KIND_STATUS
      && (out_status == osp_fr_pkg::ST_NO_SYNC || out_status == osp_fr_pkg::ST_LEN_SHORT
          || out_status == osp_fr_pkg::ST_LEN_ERR)
      |-> out_frame_length == '0 && out_byte_index == '0)
    else $error("length reported before it was read");

  a_sum_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == osp_fr_pkg::KIND_STATUS
      && (out_status == osp_fr_pkg::ST_OK || out_status == osp_fr_pkg::ST_BAD_SUM)
      |-> out_byte_index == out_frame_length && out_frame_length != '0)
    else $error("checksum verdict on incomplete payload");

endmodule

bind osp_frame_receiver_unit osp_fr_chk u_osp_fr_chk (.*);

`default_nettype wire

/* sim/tb_osp_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_osp_frame_receiver_unit
// Self-checking bench for the streaming frame receiver. A queue-fed driver
// offers link events in random bursts, and a receiver stalls on its own
// pattern with long hold-offs. A predictor of the deframer works out every
// payload and status beat, and the monitor compares the beats in order. The
// run covers directed corner cases, then random traffic under several
// register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_osp_frame_receiver_unit;

  localparam logic [1:0] ACT_ERROR    = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  localparam logic [osp_fr_pkg::AddrWidth-1:0] ADDR_PATIENCE = 'd0;
  localparam logic [osp_fr_pkg::AddrWidth-1:0] ADDR_MAX_LEN  = 'd4;

  localparam int unsigned IDLE_PAUSE  = 6;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_EVENTS = 180;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, LEN_HIGH, LEN_LOW, PAYLOAD, SUM_HIGH, SUM_LOW
  } deframe_phase_t;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] rx;
  } link_event_t;

  typedef struct packed {
    logic                            kind;
    logic [7:0]                      data;
    logic [osp_fr_pkg::LenWidth-1:0] index;
    logic [osp_fr_pkg::LenWidth-1:0] length;
    logic [2:0]                      status;
  } frame_beat_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [1:0]                       in_action = osp_fr_pkg::ACT_BYTE;
  logic [7:0]                       in_rx_byte = 8'h00;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             out_kind;
  logic [7:0]                       out_payload_byte;
  logic [osp_fr_pkg::LenWidth-1:0]  out_byte_index;
  logic [osp_fr_pkg::LenWidth-1:0]  out_frame_length;
  logic [2:0]                       out_status;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [osp_fr_pkg::AddrWidth-1:0] paddr = '0;
  logic [osp_fr_pkg::DataWidth-1:0] pwdata = '0;
  logic [osp_fr_pkg::DataWidth-1:0] prdata;
  logic                             pready;

  osp_frame_receiver_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  link_event_t pending_events[$];
  frame_beat_t deframed_beats[$];

  // predictor state and register copies
  logic [osp_fr_pkg::CfgWidth-1:0] patience_cfg;
  logic [osp_fr_pkg::CfgWidth-1:0] max_len_cfg;
  deframe_phase_t                  hunt_phase;
  logic [15:0]                     patience_left;
  logic [7:0]                      len_high;
  logic [osp_fr_pkg::LenWidth-1:0] payload_len;
  logic [osp_fr_pkg::LenWidth-1:0] bytes_out;
  logic [osp_fr_pkg::SumWidth-1:0] data_sum;
  logic [7:0]                      sum_high;

  int unsigned events_queued = 0;
  int unsigned fault_count = 0;
  int unsigned payload_beats = 0;
  int unsigned status_count [8];
  int unsigned cycle_count = 0;

  logic        in_fired = 1'b0;
  link_event_t next_event;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;

  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned next_hold_at = 300;

  task automatic restart_hunt();
    hunt_phase    = HUNT_FIRST;
    patience_left = patience_cfg;
    len_high      = '0;
    payload_len   = '0;
    bytes_out     = '0;
    data_sum      = '0;
    sum_high      = '0;
  endtask

  task automatic post_status(input logic [2:0] st,
                             input logic [osp_fr_pkg::LenWidth-1:0] len);
    deframed_beats.insert(deframed_beats.size(),
                          {osp_fr_pkg::KIND_STATUS, 8'h00, bytes_out, len, st});
    restart_hunt();
  endtask

  task automatic spend_patience();
    if (patience_left <= 16'd1) post_status(osp_fr_pkg::ST_NO_SYNC, '0);
    else patience_left = patience_left - 16'd1;
  endtask

  task automatic deframe_event(input logic [1:0] act, input logic [7:0] b);
    logic got;
    got = (act == osp_fr_pkg::ACT_BYTE);
    case (hunt_phase)
      HUNT_FIRST: begin
        if (got && b == osp_fr_pkg::START_A) hunt_phase = HUNT_SECOND;
        else if (!(got && b == osp_fr_pkg::START_B)) spend_patience();
      end
      HUNT_SECOND: begin
        if (!got) spend_patience();
        else if (b == osp_fr_pkg::START_B) hunt_phase = LEN_HIGH;
        else if (b != osp_fr_pkg::START_A) begin
          hunt_phase = HUNT_FIRST;
          spend_patience();
        end
      end
      LEN_HIGH, LEN_LOW: begin
        if (!got) begin
          post_status((act == osp_fr_pkg::ACT_TIMEOUT) ? osp_fr_pkg::ST_LEN_SHORT
                                                       : osp_fr_pkg::ST_LEN_ERR, '0);
        end else if (hunt_phase == LEN_HIGH) begin
          len_high   = b;
          hunt_phase = LEN_LOW;
        end else begin
          payload_len = {len_high, b};
          if (payload_len == '0 || payload_len > max_len_cfg) begin
            post_status(osp_fr_pkg::ST_LEN_RANGE, payload_len);
          end else begin
            bytes_out  = '0;
            data_sum   = '0;
            hunt_phase = PAYLOAD;
          end
        end
      end
      PAYLOAD: begin
        if (!got) begin
          post_status(osp_fr_pkg::ST_SHORT, payload_len);
        end else begin
          deframed_beats.insert(deframed_beats.size(),
                                {osp_fr_pkg::KIND_PAYLOAD, b, bytes_out, payload_len,
                                 osp_fr_pkg::ST_OK});
          data_sum  = data_sum + b;
          bytes_out = bytes_out + 1'b1;
          if (bytes_out >= payload_len) hunt_phase = SUM_HIGH;
        end
      end
      SUM_HIGH: begin
        if (!got) begin
          post_status(osp_fr_pkg::ST_SHORT, payload_len);
        end else begin
          sum_high   = b;
          hunt_phase = SUM_LOW;
        end
      end
      SUM_LOW: begin
        if (!got) post_status(osp_fr_pkg::ST_SHORT, payload_len);
        else if ({sum_high, b} == {1'b0, data_sum}) post_status(osp_fr_pkg::ST_OK, payload_len);
        else post_status(osp_fr_pkg::ST_BAD_SUM, payload_len);
      end
      default: restart_hunt();
    endcase
  endtask

  function automatic void report_fault(input string what, input frame_beat_t want,
                                       input frame_beat_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t %s: expected kind %0d byte %02h index %0d length %0d status %0d",
               $realtime, what, want.kind, want.data, want.index, want.length, want.status);
      $display("    got kind %0d byte %02h index %0d length %0d status %0d",
               got.kind, got.data, got.index, got.length, got.status);
    end
  endfunction

  task automatic queue_event(input logic [1:0] act, input logic [7:0] b);
    pending_events.insert(pending_events.size(), {act, b});
    events_queued++;
  endtask

  task automatic queue_header(input logic [15:0] len);
    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_A);
    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_B);
    queue_event(osp_fr_pkg::ACT_BYTE, len[15:8]);
    queue_event(osp_fr_pkg::ACT_BYTE, len[7:0]);
  endtask

  // cut: bytes delivered after the length before the failed read
  task automatic queue_frame(input logic [15:0] len, input int unsigned cut,
                             input logic [1:0] fail_act, input logic [15:0] sum_flip);
    logic [osp_fr_pkg::SumWidth-1:0] sum;
    logic [7:0]                      b;
    logic [15:0]                     chk;
    int unsigned                     i;
    sum = '0;
    queue_header(len);
    for (i = 0; i < len && i < cut; i++) begin
      b   = 8'($urandom);
      sum = sum + b;
      queue_event(osp_fr_pkg::ACT_BYTE, b);
    end
    chk = {1'b0, sum} ^ sum_flip;
    if (cut > len) queue_event(osp_fr_pkg::ACT_BYTE, chk[15:8]);
    if (cut > len + 1) queue_event(osp_fr_pkg::ACT_BYTE, chk[7:0]);
    if (cut < len + 2) queue_event(fail_act, 8'($urandom));
  endtask

  task automatic set_register(input logic [osp_fr_pkg::AddrWidth-1:0] addr,
                              input logic [15:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {16'h0000, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_PATIENCE) begin
      patience_cfg = value;
      if (hunt_phase == HUNT_FIRST || hunt_phase == HUNT_SECOND) patience_left = value;
    end else begin
      max_len_cfg = value;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_valid || deframed_beats.size() != 0)
      @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // link driver: bursts of events with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        next_event = pending_events.pop_front();
        in_valid   <= 1'b1;
        in_action  <= next_event.act;
        in_rx_byte <= next_event.rx;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: stall pattern plus long hold-offs while events are queued
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (holds_done < 3 && rx_cycle >= next_hold_at && pending_events.size() > 40) begin
        hold_left    <= $urandom_range(200, 400);
        holds_done   <= holds_done + 1;
        next_hold_at <= rx_cycle + 2500;
        out_ready    <= 1'b0;
      end else begin
        out_ready <= ready_pattern[0];
        if (rx_cycle[5:0] == 6'd0) begin
          if ($urandom_range(0, 3) == 0) ready_pattern <= 16'hFFFF;
          else ready_pattern <= 16'($urandom | $urandom) | 16'h0001;
        end else begin
          ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    frame_beat_t got;
    frame_beat_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_kind, out_payload_byte, out_byte_index, out_frame_length, out_status};
        if (deframed_beats.size() == 0) begin
          report_fault("unexpected beat", '0, got);
        end else begin
          want = deframed_beats.pop_front();
          if (got !== want) report_fault("beat mismatch", want, got);
          if (want.kind == osp_fr_pkg::KIND_STATUS) status_count[want.status]++;
          else payload_beats++;
        end
      end
      if (in_valid && in_ready) deframe_event(in_action, in_rx_byte);
    end
    in_fired <= rst_n && in_valid && in_ready;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned         s;
    int unsigned         phase_end;
    int unsigned         pick;
    int unsigned         len_cap;
    logic [15:0]         len;
    logic [15:0]         pat;
    logic [15:0]         mlen;

    patience_cfg = osp_fr_pkg::PATIENCE_RESET;
    max_len_cfg  = osp_fr_pkg::MAX_LEN_RESET;
    restart_hunt();
    foreach (status_count[i]) status_count[i] = 0;

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // reset settings: a clean frame through the start-byte corners, then a zero length and length reads cut short
    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_B);
    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_A);
    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_A);
    queue_event(osp_fr_pkg::ACT_BYTE, 8'h33);
    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_A);
    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_B);
    queue_event(osp_fr_pkg::ACT_BYTE, 8'h00);
    queue_event(osp_fr_pkg::ACT_BYTE, 8'h03);
    queue_event(osp_fr_pkg::ACT_BYTE, 8'h00);
    queue_event(osp_fr_pkg::ACT_BYTE, 8'hFF);
    queue_event(osp_fr_pkg::ACT_BYTE, 8'h55);
    queue_event(osp_fr_pkg::ACT_BYTE, 8'h01);
    queue_event(osp_fr_pkg::ACT_BYTE, 8'h54);
    queue_header(16'h0000);
    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_A);
    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_B);
    queue_event(osp_fr_pkg::ACT_TIMEOUT, 8'h00);
    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_A);
    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_B);
    queue_event(ACT_RESERVED, 8'hFF);
    wait_idle();

    // tight patience runs out; length above a limit of one
    set_register(ADDR_PATIENCE, 16'd3);
    set_register(ADDR_MAX_LEN, 16'd1);
    queue_event(osp_fr_pkg::ACT_BYTE, 8'h11);
    queue_event(osp_fr_pkg::ACT_TIMEOUT, 8'h00);
    queue_event(ACT_ERROR, 8'hA5);
    queue_header(16'h0002);

    for (s = 0; s < 6; s++) begin
      case (s)
        0: begin pat = 16'd1;                      mlen = 16'hFFFF;              end
        1: begin pat = 16'hFFFF;                   mlen = 16'd12;                end
        2: begin pat = osp_fr_pkg::PATIENCE_RESET; mlen = osp_fr_pkg::MAX_LEN_RESET; end
        3: begin pat = 16'd7;                      mlen = 16'd300;               end
        default: begin
          pat  = 16'($urandom_range(1, 64));
          mlen = 16'($urandom_range(1, 20));
        end
      endcase
      wait_idle();
      set_register(ADDR_PATIENCE, pat);
      set_register(ADDR_MAX_LEN, mlen);
      if (s == 3) queue_frame(16'd260, 262, osp_fr_pkg::ACT_TIMEOUT, 16'h0000);
      len_cap   = (mlen < 12) ? mlen : 12;
      phase_end = events_queued + PHASE_EVENTS;
      while (events_queued < phase_end) begin
        pick = $urandom_range(0, 99);
        len  = 16'($urandom_range(1, len_cap));
        if (pick < 55) begin
          queue_frame(len, len + 2, osp_fr_pkg::ACT_TIMEOUT, 16'h0000);
        end else if (pick < 63) begin
          queue_frame(len, len + 2, osp_fr_pkg::ACT_TIMEOUT, 16'($urandom_range(1, 65535)));
        end else if (pick < 70) begin
          queue_frame(len, $urandom_range(0, len + 1), 2'($urandom_range(1, 3)), 16'h0000);
        end else if (pick < 76) begin
          if (mlen == 16'hFFFF) begin
            if ($urandom_range(0, 1) == 0) queue_header(16'h0000);
            else queue_frame(16'hFFFF, $urandom_range(0, 3), ACT_ERROR, 16'h0000);
          end else begin
            case ($urandom_range(0, 2))
              0: len = 16'h0000;
              1: len = mlen + 16'd1;
              default: len = 16'($urandom_range(mlen + 1, 65535));
            endcase
            queue_header(len);
          end
        end else if (pick < 82) begin
          queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_A);
          queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_B);
          if ($urandom_range(0, 1) == 1) queue_event(osp_fr_pkg::ACT_BYTE, 8'($urandom));
          queue_event(2'($urandom_range(1, 3)), 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
              0, 1:    queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_A);
              2:       queue_event(osp_fr_pkg::ACT_BYTE, osp_fr_pkg::START_B);
              3, 4:    queue_event(2'($urandom_range(1, 3)), 8'($urandom));
              default: queue_event(osp_fr_pkg::ACT_BYTE, 8'($urandom));
            endcase
          end
        end
      end
    end

    wait_idle();
    $display("covered %0d link events, %0d payload beats, %0d receiver hold-offs",
             events_queued, payload_beats, holds_done);
    $display("frame statuses: ok %0d, bad sum %0d, short %0d, len range %0d, %s %0d %0d, %s %0d",
             status_count[osp_fr_pkg::ST_OK], status_count[osp_fr_pkg::ST_BAD_SUM],
             status_count[osp_fr_pkg::ST_SHORT], status_count[osp_fr_pkg::ST_LEN_RANGE],
             "len short/err", status_count[osp_fr_pkg::ST_LEN_SHORT],
             status_count[osp_fr_pkg::ST_LEN_ERR], "no sync",
             status_count[osp_fr_pkg::ST_NO_SYNC]);
    if (fault_count == 0 && deframed_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/osp_fr_pkg.sv
src/osp_fr_regs.sv
src/osp_fr_core.sv
src/osp_frame_receiver_unit.sv
src/osp_fr_chk.sv
sim/tb_osp_frame_receiver_unit.sv
